[rtl/stl_pkg.sv]
// Shared types, token and character codes, and keyword table for the source token lexer.
package stl_pkg;

    // Sizes
    localparam int MAX_IDENT_LEN = 15;
    localparam int LINE_W        = 16;
    localparam int LINE_NO_W     = 16;
    localparam int IDENT_DEPTH   = 15;
    localparam int WORD_DEPTH    = 6;
    localparam int KW_COUNT      = 9;

    localparam logic [4:0]        IDENT_MAX = 5'(MAX_IDENT_LEN);
    localparam logic [2:0]        WORD_MAX  = 3'(WORD_DEPTH);
    localparam logic [2:0]        WORD_SAT  = 3'd7;
    localparam logic [LINE_W-1:0] LINE_ONE  = LINE_W'(1);
    localparam logic [LINE_W-1:0] LINE_TOP  = '1;

    // Token kinds
    localparam logic [4:0] K_ERROR   = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_NUMBER  = 5'd2;
    localparam logic [4:0] K_PLUS    = 5'd3;
    localparam logic [4:0] K_MUL     = 5'd4;
    localparam logic [4:0] K_MINUS   = 5'd5;
    localparam logic [4:0] K_DIV     = 5'd6;
    localparam logic [4:0] K_KW_BASE = 5'd7;
    localparam logic [4:0] K_LT      = 5'd16;
    localparam logic [4:0] K_LE      = 5'd17;
    localparam logic [4:0] K_EQEQ    = 5'd18;
    localparam logic [4:0] K_NE      = 5'd19;
    localparam logic [4:0] K_GT      = 5'd20;
    localparam logic [4:0] K_GE      = 5'd21;
    localparam logic [4:0] K_OR      = 5'd22;
    localparam logic [4:0] K_AND     = 5'd23;
    localparam logic [4:0] K_COMMA   = 5'd24;
    localparam logic [4:0] K_SEMI    = 5'd25;
    localparam logic [4:0] K_LBRACE  = 5'd26;
    localparam logic [4:0] K_RBRACE  = 5'd27;
    localparam logic [4:0] K_LPAREN  = 5'd28;
    localparam logic [4:0] K_RPAREN  = 5'd29;
    localparam logic [4:0] K_ASSIGN  = 5'd30;
    localparam logic [4:0] K_EOS     = 5'd31;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] HEX_TEN   = 8'd10;

    // Keywords, first character in the lowest byte, zero padded
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h00006C6F6F62,   // bool
        48'h000065736C65,   // else
        48'h000000006669,   // if
        48'h000000746E69,   // int
        48'h00006E69616D,   // main
        48'h66746E697270,   // printf
        48'h00666E616373,   // scanf
        48'h000064696F76,   // void
        48'h00656C696877    // while
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd4, 3'd4, 3'd2, 3'd3, 3'd4, 3'd6, 3'd5, 3'd4, 3'd5
    };

    // One classified source byte
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       lower;
        logic       upper;
        logic       digit;
        logic       hex_ok;
        logic [3:0] hex_d;
    } t_cls;

    // One result token
    typedef struct packed {
        logic [4:0]           kind;
        logic [LINE_NO_W-1:0] line;
        logic [31:0]          value;
        logic                 ovf;
        logic [3:0]           len;
        logic [63:0]          lo;
        logic [55:0]          hi;
    } t_tok;

    localparam t_tok TOK_ZERO = '0;

    // Scanner modes
    typedef enum logic [15:0] {
        M_IDLE    = 16'b0000_0000_0000_0001,
        M_LINEC   = 16'b0000_0000_0000_0010,
        M_BLOCK   = 16'b0000_0000_0000_0100,
        M_STAR    = 16'b0000_0000_0000_1000,
        M_SLASH   = 16'b0000_0000_0001_0000,
        M_LT      = 16'b0000_0000_0010_0000,
        M_GT      = 16'b0000_0000_0100_0000,
        M_BANG    = 16'b0000_0000_1000_0000,
        M_EQ      = 16'b0000_0001_0000_0000,
        M_AMP     = 16'b0000_0010_0000_0000,
        M_BAR     = 16'b0000_0100_0000_0000,
        M_WORD    = 16'b0000_1000_0000_0000,
        M_IDSTART = 16'b0001_0000_0000_0000,
        M_IDENT   = 16'b0010_0000_0000_0000,
        M_ZERO    = 16'b0100_0000_0000_0000,
        M_HEX     = 16'b1000_0000_0000_0000
    } t_mode;

    // Line counter seen on the token port
    function automatic logic [LINE_NO_W-1:0] line_out(input logic [LINE_W-1:0] v);
        return LINE_NO_W'(v);
    endfunction

    // Saturating line increment
    function automatic logic [LINE_W-1:0] line_next(input logic [LINE_W-1:0] v);
        logic [LINE_W-1:0] res;
        res = v;
        if (v != LINE_TOP) begin
            res = v + LINE_ONE;
        end
        return res;
    endfunction

    // Keyword match: bit 5 is hit, bits 4:0 the kind
    function automatic logic [5:0] kw_lookup(input logic [47:0] text, input logic [2:0] len);
        logic [47:0] mask;
        logic [5:0]  res;
        mask = '0;
        res  = {1'b0, K_ERROR};
        for (int j = 0; j < WORD_DEPTH; j++) begin
            if (3'(j) < len) begin
                mask[8*j +: 8] = 8'hFF;
            end
        end
        for (int k = 0; k < KW_COUNT; k++) begin
            if (len == KW_LEN[k] && (text & mask) == KW_TEXT[k]) begin
                res = {1'b1, K_KW_BASE + 5'(k)};
            end
        end
        return res;
    endfunction

endpackage

[rtl/source_token_lexer.sv]
// Top level of the streaming source token lexer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  bytes   | in        | i_valid / o_ready  | i_char_in, i_is_end
//  tokens  | out       | o_valid / i_ready  | o_kind, o_line_no, o_number_value,
//          |           |                    | o_number_overflow, o_ident_length,
//          |           |                    | o_ident_text_low, o_ident_text_high, o_last
//
// One byte per cycle is taken while the output keeps draining. A byte that gives two
// tokens (a held token closed by a byte that is a token itself, or end of input after
// a held token) occupies the scanner until both are loaded, one per output beat.
// An input beat reaches the token port through the queue entry, then the output register.
// Reset is synchronous: queue empty, scanner idle on line 1, no token pending.
// The two-entry byte queue lets input beats keep arriving while a token waits.
module source_token_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_is_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_kind,
    output logic [15:0] o_line_no,
    output logic [31:0] o_number_value,
    output logic        o_number_overflow,
    output logic [3:0]  o_ident_length,
    output logic [63:0] o_ident_text_low,
    output logic [55:0] o_ident_text_high,
    output logic        o_last
);

    logic          q_push;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    stl_pkg::t_cls f_cls;
    stl_pkg::t_cls q_cls;

    // Classify incoming bytes
    stl_front u_front (
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_char_in (i_char_in),
        .i_is_end  (i_is_end),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_cls     (f_cls)
    );

    // Decouple front and scanner
    stl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_cls),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cls),
        .i_pop   (q_pop)
    );

    // Scan and emit tokens
    stl_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_data          (q_cls),
        .o_q_pop           (q_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_line_no         (o_line_no),
        .o_number_value    (o_number_value),
        .o_number_overflow (o_number_overflow),
        .o_ident_length    (o_ident_length),
        .o_ident_text_low  (o_ident_text_low),
        .o_ident_text_high (o_ident_text_high),
        .o_last            (o_last)
    );

    // End of stream is always the final beat of its byte
    a_eos_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == stl_pkg::K_EOS) |-> o_last)
        else $error("end-of-stream token not marked last");

    // A first beat of a pair is followed by its second beat
    a_pair_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("second token of a byte missing");

    // Identifiers hold at least underscore and one letter
    a_ident_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == stl_pkg::K_IDENT) |-> (o_ident_length >= 4'd2))
        else $error("identifier token too short");

    // Number fields are clear on every other kind
    a_num_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != stl_pkg::K_NUMBER) |->
            (o_number_value == 32'd0 && !o_number_overflow))
        else $error("number fields set on non-number token");

endmodule

[rtl/stl_front.sv]
// Front end: takes source bytes and classifies each one for the scanner queue.
module stl_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_char_in,
    input  logic          i_is_end,
    input  logic          i_full,
    output logic          o_push,
    output stl_pkg::t_cls o_cls
);

    logic [7:0] dec_off;
    logic [7:0] low_off;
    logic [7:0] up_off;

    // Take a beat whenever the queue has room
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign dec_off = i_char_in - stl_pkg::CH_ZERO;
    assign low_off = i_char_in - stl_pkg::CH_LOW_A + stl_pkg::HEX_TEN;
    assign up_off  = i_char_in - stl_pkg::CH_UP_A + stl_pkg::HEX_TEN;

    // Classify the byte
    always_comb begin
        o_cls.ch     = i_char_in;
        o_cls.eos    = i_is_end || (i_char_in == stl_pkg::CH_NUL);
        o_cls.lower  = (i_char_in >= stl_pkg::CH_LOW_A) && (i_char_in <= stl_pkg::CH_LOW_Z);
        o_cls.upper  = (i_char_in >= stl_pkg::CH_UP_A) && (i_char_in <= stl_pkg::CH_UP_Z);
        o_cls.digit  = (i_char_in >= stl_pkg::CH_ZERO) && (i_char_in <= stl_pkg::CH_NINE);
        o_cls.hex_ok = 1'b1;
        o_cls.hex_d  = dec_off[3:0];
        if (o_cls.digit) begin
            o_cls.hex_d = dec_off[3:0];
        end else if (i_char_in >= stl_pkg::CH_LOW_A && i_char_in <= stl_pkg::CH_LOW_F) begin
            o_cls.hex_d = low_off[3:0];
        end else if (i_char_in >= stl_pkg::CH_UP_A && i_char_in <= stl_pkg::CH_UP_F) begin
            o_cls.hex_d = up_off[3:0];
        end else begin
            o_cls.hex_ok = 1'b0;
        end
    end

endmodule

[rtl/stl_queue.sv]
// Two-entry queue of classified bytes between the front end and the scanner.
module stl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stl_pkg::t_cls i_data,
    output logic          o_full,
    output logic          o_valid,
    output stl_pkg::t_cls o_data,
    input  logic          i_pop
);

    stl_pkg::t_cls r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[rtl/stl_back.sv]
// Back end: scanner state machine, token assembly and the output register.
module stl_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  stl_pkg::t_cls          i_q_data,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [4:0]             o_kind,
    output logic [stl_pkg::LINE_NO_W-1:0] o_line_no,
    output logic [31:0]            o_number_value,
    output logic                   o_number_overflow,
    output logic [3:0]             o_ident_length,
    output logic [63:0]            o_ident_text_low,
    output logic [55:0]            o_ident_text_high,
    output logic                   o_last
);

    // Scanner state
    stl_pkg::t_mode               r_mode, n_mode;
    logic [stl_pkg::LINE_W-1:0]   r_line, n_line;
    logic [stl_pkg::LINE_W-1:0]   r_tok_line, n_tok_line;
    logic [4:0]                   r_ilen, n_ilen;
    logic [2:0]                   r_wlen, n_wlen;
    logic [31:0]                  r_hex, n_hex;
    logic                         r_ovf, n_ovf;
    logic                         r_hex_x, n_hex_x;
    logic [7:0]                   r_ident [stl_pkg::IDENT_DEPTH];
    logic [7:0]                   r_word [stl_pkg::WORD_DEPTH];

    // Output stage
    logic                         r_second;
    logic                         r_out_valid;
    stl_pkg::t_tok                r_out;
    logic                         r_out_last;

    // Byte and store writes
    stl_pkg::t_cls                cls;
    logic                         id_we;
    logic [3:0]                   id_addr;
    logic                         wd_we;
    logic [2:0]                   wd_addr;
    logic [stl_pkg::LINE_W-1:0]   line_inc;

    // Step control
    logic                         do_finish;
    logic                         do_start;
    logic                         pair_hit;
    logic [7:0]                   pair_ch;
    logic [4:0]                   pair_kind;

    // Tokens
    logic                         fin_has;
    stl_pkg::t_tok                fin_tok;
    logic                         st_has;
    stl_pkg::t_tok                st_tok;
    logic                         ta_has;
    stl_pkg::t_tok                ta;
    logic                         tb_has;
    stl_pkg::t_tok                tb;
    logic [47:0]                  word_text;
    logic [5:0]                   kw_res;
    logic [63:0]                  id_lo;
    logic [55:0]                  id_hi;

    logic                         any_tok;
    logic                         two_tok;
    logic                         advance;
    logic                         load;
    logic                         commit;

    assign cls      = i_q_data;
    assign line_inc = stl_pkg::line_next(r_line);

    // Pack stored characters
    always_comb begin
        word_text = '0;
        for (int j = 0; j < stl_pkg::WORD_DEPTH; j++) begin
            word_text[8*j +: 8] = r_word[j];
        end
        id_lo = '0;
        id_hi = '0;
        for (int i = 0; i < 8; i++) begin
            if (5'(i) < r_ilen) begin
                id_lo[8*i +: 8] = r_ident[i];
            end
        end
        for (int i = 8; i < stl_pkg::IDENT_DEPTH; i++) begin
            if (5'(i) < r_ilen) begin
                id_hi[8*(i-8) +: 8] = r_ident[i];
            end
        end
    end

    assign kw_res = stl_pkg::kw_lookup(word_text, r_wlen);

    // Token held by the current mode
    always_comb begin
        fin_has      = 1'b1;
        fin_tok      = stl_pkg::TOK_ZERO;
        fin_tok.line = stl_pkg::line_out(r_tok_line);
        fin_tok.kind = stl_pkg::K_ERROR;
        case (r_mode)
            stl_pkg::M_SLASH: fin_tok.kind = stl_pkg::K_DIV;
            stl_pkg::M_LT:    fin_tok.kind = stl_pkg::K_LT;
            stl_pkg::M_GT:    fin_tok.kind = stl_pkg::K_GT;
            stl_pkg::M_EQ:    fin_tok.kind = stl_pkg::K_ASSIGN;
            stl_pkg::M_BANG, stl_pkg::M_AMP, stl_pkg::M_BAR,
            stl_pkg::M_IDSTART, stl_pkg::M_ZERO: fin_tok.kind = stl_pkg::K_ERROR;
            stl_pkg::M_WORD: begin
                if (kw_res[5]) begin
                    fin_tok.kind = kw_res[4:0];
                end
            end
            stl_pkg::M_IDENT: begin
                if (r_ilen <= stl_pkg::IDENT_MAX) begin
                    fin_tok.kind = stl_pkg::K_IDENT;
                    fin_tok.len  = r_ilen[3:0];
                    fin_tok.lo   = id_lo;
                    fin_tok.hi   = id_hi;
                end
            end
            stl_pkg::M_HEX: begin
                fin_tok.kind  = stl_pkg::K_NUMBER;
                fin_tok.value = r_hex;
                fin_tok.ovf   = r_ovf;
            end
            default: fin_has = 1'b0;
        endcase
    end

    // Token a byte makes when scanned from idle
    always_comb begin
        st_has      = 1'b0;
        st_tok      = stl_pkg::TOK_ZERO;
        st_tok.line = stl_pkg::line_out(r_line);
        st_tok.kind = stl_pkg::K_ERROR;
        if (!cls.lower) begin
            case (cls.ch)
                stl_pkg::CH_PLUS:   begin st_has = 1'b1; st_tok.kind = stl_pkg::K_PLUS;   end
                stl_pkg::CH_STAR:   begin st_has = 1'b1; st_tok.kind = stl_pkg::K_MUL;    end
                stl_pkg::CH_MINUS:  begin st_has = 1'b1; st_tok.kind = stl_pkg::K_MINUS;  end
                stl_pkg::CH_COMMA:  begin st_has = 1'b1; st_tok.kind = stl_pkg::K_COMMA;  end
                stl_pkg::CH_SEMI:   begin st_has = 1'b1; st_tok.kind = stl_pkg::K_SEMI;   end
                stl_pkg::CH_LBRACE: begin st_has = 1'b1; st_tok.kind = stl_pkg::K_LBRACE; end
                stl_pkg::CH_RBRACE: begin st_has = 1'b1; st_tok.kind = stl_pkg::K_RBRACE; end
                stl_pkg::CH_LPAREN: begin st_has = 1'b1; st_tok.kind = stl_pkg::K_LPAREN; end
                stl_pkg::CH_RPAREN: begin st_has = 1'b1; st_tok.kind = stl_pkg::K_RPAREN; end
                stl_pkg::CH_TAB, stl_pkg::CH_LF, stl_pkg::CH_CR, stl_pkg::CH_SPACE,
                stl_pkg::CH_UNDER, stl_pkg::CH_SLASH, stl_pkg::CH_LT, stl_pkg::CH_GT,
                stl_pkg::CH_BANG, stl_pkg::CH_EQ, stl_pkg::CH_AMP, stl_pkg::CH_BAR,
                stl_pkg::CH_ZERO: st_has = 1'b0;
                default: st_has = 1'b1;
            endcase
        end
    end

    // Second character and kind of two-character operators
    always_comb begin
        pair_ch   = stl_pkg::CH_EQ;
        pair_kind = stl_pkg::K_ERROR;
        case (r_mode)
            stl_pkg::M_LT:   pair_kind = stl_pkg::K_LE;
            stl_pkg::M_GT:   pair_kind = stl_pkg::K_GE;
            stl_pkg::M_BANG: pair_kind = stl_pkg::K_NE;
            stl_pkg::M_EQ:   pair_kind = stl_pkg::K_EQEQ;
            stl_pkg::M_AMP:  begin pair_ch = stl_pkg::CH_AMP; pair_kind = stl_pkg::K_AND; end
            stl_pkg::M_BAR:  begin pair_ch = stl_pkg::CH_BAR; pair_kind = stl_pkg::K_OR;  end
            default: ;
        endcase
    end

    // Next scanner state for the byte at the queue head
    always_comb begin
        n_mode     = r_mode;
        n_line     = r_line;
        n_tok_line = r_tok_line;
        n_ilen     = r_ilen;
        n_wlen     = r_wlen;
        n_hex      = r_hex;
        n_ovf      = r_ovf;
        n_hex_x    = r_hex_x;
        id_we      = 1'b0;
        id_addr    = r_ilen[3:0];
        wd_we      = 1'b0;
        wd_addr    = r_wlen;
        do_finish  = 1'b0;
        do_start   = 1'b0;
        pair_hit   = 1'b0;
        if (cls.eos) begin
            // Flush the held token, then restart the stream
            do_finish  = 1'b1;
            n_line     = stl_pkg::LINE_ONE;
            n_tok_line = stl_pkg::LINE_ONE;
        end else begin
            case (r_mode)
                stl_pkg::M_IDLE: do_start = 1'b1;
                stl_pkg::M_LINEC: begin
                    if (cls.ch == stl_pkg::CH_LF) begin
                        n_line = line_inc;
                        n_mode = stl_pkg::M_IDLE;
                    end
                end
                stl_pkg::M_BLOCK: begin
                    if (cls.ch == stl_pkg::CH_STAR) begin
                        n_mode = stl_pkg::M_STAR;
                    end else if (cls.ch == stl_pkg::CH_LF) begin
                        n_line = line_inc;
                    end
                end
                stl_pkg::M_STAR: begin
                    if (cls.ch == stl_pkg::CH_SLASH) begin
                        n_mode = stl_pkg::M_IDLE;
                    end else if (cls.ch != stl_pkg::CH_STAR) begin
                        if (cls.ch == stl_pkg::CH_LF) begin
                            n_line = line_inc;
                        end
                        n_mode = stl_pkg::M_BLOCK;
                    end
                end
                stl_pkg::M_SLASH: begin
                    if (cls.ch == stl_pkg::CH_SLASH) begin
                        n_mode = stl_pkg::M_LINEC;
                    end else if (cls.ch == stl_pkg::CH_STAR) begin
                        n_mode = stl_pkg::M_BLOCK;
                    end else begin
                        do_finish = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                stl_pkg::M_LT, stl_pkg::M_GT, stl_pkg::M_BANG,
                stl_pkg::M_EQ, stl_pkg::M_AMP, stl_pkg::M_BAR: begin
                    if (cls.ch == pair_ch) begin
                        pair_hit = 1'b1;
                        n_mode   = stl_pkg::M_IDLE;
                    end else begin
                        do_finish = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                stl_pkg::M_WORD: begin
                    if (cls.lower) begin
                        if (r_wlen < stl_pkg::WORD_MAX) begin
                            wd_we = 1'b1;
                        end
                        if (r_wlen != stl_pkg::WORD_SAT) begin
                            n_wlen = r_wlen + 3'd1;
                        end
                    end else begin
                        do_finish = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                stl_pkg::M_IDSTART, stl_pkg::M_IDENT: begin
                    if (cls.lower || cls.upper ||
                        (cls.digit && r_mode == stl_pkg::M_IDENT)) begin
                        if (r_ilen < stl_pkg::IDENT_MAX) begin
                            id_we = 1'b1;
                        end
                        if (r_ilen <= stl_pkg::IDENT_MAX) begin
                            n_ilen = r_ilen + 5'd1;
                        end
                        n_mode = stl_pkg::M_IDENT;
                    end else begin
                        do_finish = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                stl_pkg::M_ZERO: begin
                    if (!r_hex_x && cls.ch == stl_pkg::CH_LOW_X) begin
                        n_hex_x = 1'b1;
                    end else if (r_hex_x && cls.hex_ok) begin
                        n_hex  = 32'(cls.hex_d);
                        n_mode = stl_pkg::M_HEX;
                    end else begin
                        do_finish = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                stl_pkg::M_HEX: begin
                    if (cls.hex_ok) begin
                        if (r_hex[31:28] != 4'd0) begin
                            n_ovf = 1'b1;
                        end
                        n_hex = {r_hex[27:0], cls.hex_d};
                    end else begin
                        do_finish = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (do_finish) begin
            n_mode = stl_pkg::M_IDLE;
        end

        // Scan the byte as the start of a new token
        if (do_start) begin
            n_tok_line = r_line;
            if (cls.lower) begin
                wd_we   = 1'b1;
                wd_addr = 3'd0;
                n_wlen  = 3'd1;
                n_mode  = stl_pkg::M_WORD;
            end else begin
                case (cls.ch)
                    stl_pkg::CH_LF: n_line = line_inc;
                    stl_pkg::CH_UNDER: begin
                        id_we   = 1'b1;
                        id_addr = 4'd0;
                        n_ilen  = 5'd1;
                        n_mode  = stl_pkg::M_IDSTART;
                    end
                    stl_pkg::CH_SLASH: n_mode = stl_pkg::M_SLASH;
                    stl_pkg::CH_LT:    n_mode = stl_pkg::M_LT;
                    stl_pkg::CH_GT:    n_mode = stl_pkg::M_GT;
                    stl_pkg::CH_BANG:  n_mode = stl_pkg::M_BANG;
                    stl_pkg::CH_EQ:    n_mode = stl_pkg::M_EQ;
                    stl_pkg::CH_AMP:   n_mode = stl_pkg::M_AMP;
                    stl_pkg::CH_BAR:   n_mode = stl_pkg::M_BAR;
                    stl_pkg::CH_ZERO: begin
                        n_hex_x = 1'b0;
                        n_hex   = 32'd0;
                        n_ovf   = 1'b0;
                        n_mode  = stl_pkg::M_ZERO;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Order the tokens this byte causes
    always_comb begin
        ta      = fin_tok;
        ta_has  = do_finish && fin_has;
        tb      = st_tok;
        tb_has  = do_start && st_has;
        if (cls.eos) begin
            tb      = stl_pkg::TOK_ZERO;
            tb.kind = stl_pkg::K_EOS;
            tb.line = stl_pkg::line_out(r_line);
            tb_has  = 1'b1;
        end else if (pair_hit) begin
            ta      = stl_pkg::TOK_ZERO;
            ta.kind = pair_kind;
            ta.line = stl_pkg::line_out(r_tok_line);
            ta_has  = 1'b1;
        end
    end

    assign any_tok = ta_has || tb_has;
    assign two_tok = ta_has && tb_has;
    assign advance = !r_out_valid || i_ready;
    assign load    = i_q_valid && any_tok && advance;
    // A two-token byte stays at the head until its second beat is loaded
    assign commit  = i_q_valid && (!any_tok || (advance && (!two_tok || r_second)));
    assign o_q_pop = commit;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= stl_pkg::M_IDLE;
            r_line      <= stl_pkg::LINE_ONE;
            r_tok_line  <= stl_pkg::LINE_ONE;
            r_ilen      <= 5'd0;
            r_wlen      <= 3'd0;
            r_hex       <= 32'd0;
            r_ovf       <= 1'b0;
            r_hex_x     <= 1'b0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_mode     <= n_mode;
                r_line     <= n_line;
                r_tok_line <= n_tok_line;
                r_ilen     <= n_ilen;
                r_wlen     <= n_wlen;
                r_hex      <= n_hex;
                r_ovf      <= n_ovf;
                r_hex_x    <= n_hex_x;
            end
            if (advance) begin
                r_out_valid <= load;
            end
            if (load) begin
                r_second <= two_tok && !r_second;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out      <= r_second ? tb : (ta_has ? ta : tb);
            r_out_last <= !two_tok || r_second;
        end
    end

    // Character stores
    always_ff @(posedge i_clk) begin
        if (commit && id_we) begin
            r_ident[id_addr] <= cls.ch;
        end
        if (commit && wd_we) begin
            r_word[wd_addr] <= cls.ch;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_kind            = r_out.kind;
    assign o_line_no         = r_out.line;
    assign o_number_value    = r_out.value;
    assign o_number_overflow = r_out.ovf;
    assign o_ident_length    = r_out.len;
    assign o_ident_text_low  = r_out.lo;
    assign o_ident_text_high = r_out.hi;
    assign o_last            = r_out_last;

endmodule

[verif/source_token_lexer_tb.sv]
// Self-checking testbench for source_token_lexer: directed table, then random token streams.
module source_token_lexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;
    localparam int REPORT_MAX  = 10;
    localparam bit KNOWN       = 1'b1;
    localparam bit PRED        = 1'b0;
    localparam logic [4:0] NOT_HEX = 5'd16;

    // One token as seen on the output port
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line_no;
        logic [31:0] value;
        logic        ovf;
        logic [3:0]  id_len;
        logic [63:0] lo;
        logic [55:0] hi;
        logic        last;
    } t_exp_tok;

    // One source byte beat; known rows carry a typed-in single token
    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic        known;
        logic [4:0]  kind;
        logic [15:0] line_no;
    } t_src_beat;

    localparam t_src_beat DIRECTED [28] = '{
        '{stl_pkg::CH_PLUS,  1'b0, KNOWN, stl_pkg::K_PLUS,  16'd1},  // lone plus after reset
        '{8'h80,             1'b0, KNOWN, stl_pkg::K_ERROR, 16'd1},  // non-ASCII byte
        '{8'hFF,             1'b0, KNOWN, stl_pkg::K_ERROR, 16'd1},  // top byte value
        '{stl_pkg::CH_LF,    1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_LT,    1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_EQ,    1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},  // less-or-equal
        '{stl_pkg::CH_GT,    1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_SEMI,  1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},  // held greater, semicolon
        '{stl_pkg::CH_UNDER, 1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{"1",               1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},  // underscore, bad digit
        '{stl_pkg::CH_ZERO,  1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_LOW_X, 1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_UP_F,  1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_LOW_F, 1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_SPACE, 1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},  // closes hex number
        '{stl_pkg::CH_SLASH, 1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_STAR,  1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},  // block comment opens
        '{stl_pkg::CH_LF,    1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_STAR,  1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_SLASH, 1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},  // block comment closes
        '{"i",               1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_LOW_F, 1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_UP_A,  1'b1, PRED,  stl_pkg::K_ERROR, 16'd0},  // end flushes keyword
        '{stl_pkg::CH_NUL,   1'b0, KNOWN, stl_pkg::K_EOS,   16'd1},  // NUL also ends a stream
        '{stl_pkg::CH_SLASH, 1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_SLASH, 1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_LOW_A, 1'b0, PRED,  stl_pkg::K_ERROR, 16'd0},
        '{stl_pkg::CH_SPACE, 1'b1, KNOWN, stl_pkg::K_EOS,   16'd1}   // end inside line comment
    };

    string kw_words [9] = '{"bool", "else", "if", "int", "main", "printf", "scanf", "void",
                            "while"};
    string op_words [22] = '{"<", "<=", "==", "!=", ">", ">=", "||", "&&", "=", "!", "&", "|",
                             "+", "-", "*", "/", ",", ";", "{", "}", "(", ")"};
    string alnum_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    string hex_chars   = "0123456789abcdefABCDEF";

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_char_in = '0;
    logic        i_is_end = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [4:0]  o_kind;
    logic [15:0] o_line_no;
    logic [31:0] o_number_value;
    logic        o_number_overflow;
    logic [3:0]  o_ident_length;
    logic [63:0] o_ident_text_low;
    logic [55:0] o_ident_text_high;
    logic        o_last;

    source_token_lexer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_char_in         (i_char_in),
        .i_is_end          (i_is_end),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_line_no         (o_line_no),
        .o_number_value    (o_number_value),
        .o_number_overflow (o_number_overflow),
        .o_ident_length    (o_ident_length),
        .o_ident_text_low  (o_ident_text_low),
        .o_ident_text_high (o_ident_text_high),
        .o_last            (o_last)
    );

    t_src_beat src_q [$];
    t_exp_tok  pending_tokens [$];
    int        cycles = 0;
    int        fault_count = 0;
    int        tok_seen = 0;
    int        rand_start = 0;
    bit        rand_phase = 1'b0;
    bit        hold_done = 1'b0;
    t_exp_tok  mon_got;
    t_exp_tok  mon_want;

    // Lexer shadow state
    stl_pkg::t_mode lx_mode = stl_pkg::M_IDLE;
    logic [15:0] lx_line = 16'd1;
    logic [15:0] lx_tok_line = 16'd1;
    logic [7:0]  lx_id [15];
    logic [4:0]  lx_id_len = '0;
    logic [7:0]  lx_wd [6];
    logic [2:0]  lx_wd_len = '0;
    logic        lx_x_seen = 1'b0;
    logic [31:0] lx_hex = '0;
    logic        lx_ovf = 1'b0;
    t_exp_tok    step_tok [2];
    int          step_n = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit is_lower(input logic [7:0] c);
        return c >= stl_pkg::CH_LOW_A && c <= stl_pkg::CH_LOW_Z;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return is_lower(c) || (c >= stl_pkg::CH_UP_A && c <= stl_pkg::CH_UP_Z);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= stl_pkg::CH_ZERO && c <= stl_pkg::CH_NINE;
    endfunction

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = NOT_HEX;
        if (is_digit(c)) begin
            d = 5'(c - stl_pkg::CH_ZERO);
        end else if (c >= stl_pkg::CH_LOW_A && c <= stl_pkg::CH_LOW_F) begin
            d = 5'(c - stl_pkg::CH_LOW_A + stl_pkg::HEX_TEN);
        end else if (c >= stl_pkg::CH_UP_A && c <= stl_pkg::CH_UP_F) begin
            d = 5'(c - stl_pkg::CH_UP_A + stl_pkg::HEX_TEN);
        end
        return d;
    endfunction

    // Append one token to this beat's results, two at most
    function automatic void tok_put(input logic [4:0] k, input logic [15:0] ln,
                                    input logic [31:0] v, input logic o, input logic [3:0] len,
                                    input logic [63:0] lo, input logic [55:0] hi);
        t_exp_tok t;
        t = '0;
        t.kind    = k;
        t.line_no = ln;
        t.value   = v;
        t.ovf     = o;
        t.id_len  = len;
        t.lo      = lo;
        t.hi      = hi;
        if (step_n < 2) begin
            step_tok[step_n] = t;
            step_n++;
        end
    endfunction

    function automatic void plain(input logic [4:0] k, input logic [15:0] ln);
        tok_put(k, ln, '0, 1'b0, '0, '0, '0);
    endfunction

    function automatic void line_bump();
        if (lx_line != stl_pkg::LINE_TOP) begin
            lx_line = lx_line + 16'd1;
        end
    endfunction

    function automatic void id_add(input logic [7:0] c);
        if (lx_id_len < stl_pkg::MAX_IDENT_LEN) begin
            lx_id[lx_id_len] = c;
        end
        if (lx_id_len <= stl_pkg::MAX_IDENT_LEN) begin
            lx_id_len = lx_id_len + 5'd1;
        end
    endfunction

    // Emit the held token, if any, and drop back to idle
    function automatic void close_held();
        logic [63:0] lo;
        logic [55:0] hi;
        logic [4:0]  k;
        bit          hit;
        int          w;
        int          i;
        case (lx_mode)
            stl_pkg::M_SLASH: plain(stl_pkg::K_DIV, lx_tok_line);
            stl_pkg::M_LT:    plain(stl_pkg::K_LT, lx_tok_line);
            stl_pkg::M_GT:    plain(stl_pkg::K_GT, lx_tok_line);
            stl_pkg::M_EQ:    plain(stl_pkg::K_ASSIGN, lx_tok_line);
            stl_pkg::M_BANG, stl_pkg::M_AMP, stl_pkg::M_BAR, stl_pkg::M_IDSTART,
            stl_pkg::M_ZERO: plain(stl_pkg::K_ERROR, lx_tok_line);
            stl_pkg::M_WORD: begin
                k = stl_pkg::K_ERROR;
                for (w = 0; w < stl_pkg::KW_COUNT; w++) begin
                    hit = (kw_words[w].len() == int'(lx_wd_len));
                    for (i = 0; hit && i < int'(lx_wd_len); i++) begin
                        if (lx_wd[i] != kw_words[w][i]) hit = 1'b0;
                    end
                    if (hit) k = stl_pkg::K_KW_BASE + 5'(w);
                end
                plain(k, lx_tok_line);
            end
            stl_pkg::M_IDENT: begin
                if (lx_id_len > stl_pkg::MAX_IDENT_LEN) begin
                    plain(stl_pkg::K_ERROR, lx_tok_line);
                end else begin
                    lo = '0;
                    hi = '0;
                    for (i = 0; i < int'(lx_id_len); i++) begin
                        if (i < 8) lo[8*i +: 8] = lx_id[i];
                        else hi[8*(i-8) +: 8] = lx_id[i];
                    end
                    tok_put(stl_pkg::K_IDENT, lx_tok_line, '0, 1'b0, lx_id_len[3:0], lo, hi);
                end
            end
            stl_pkg::M_HEX: tok_put(stl_pkg::K_NUMBER, lx_tok_line, lx_hex, lx_ovf, '0, '0, '0);
            default: ;
        endcase
        lx_mode = stl_pkg::M_IDLE;
    endfunction

    // Scan a byte from idle
    function automatic void open_tok(input logic [7:0] c);
        lx_tok_line = lx_line;
        if (is_lower(c)) begin
            lx_wd[0]  = c;
            lx_wd_len = 3'd1;
            lx_mode   = stl_pkg::M_WORD;
        end else begin
            case (c)
                stl_pkg::CH_LF: line_bump();
                stl_pkg::CH_SPACE, stl_pkg::CH_TAB, stl_pkg::CH_CR: ;
                stl_pkg::CH_UNDER: begin
                    lx_id_len = '0;
                    id_add(c);
                    lx_mode = stl_pkg::M_IDSTART;
                end
                stl_pkg::CH_PLUS:   plain(stl_pkg::K_PLUS, lx_line);
                stl_pkg::CH_STAR:   plain(stl_pkg::K_MUL, lx_line);
                stl_pkg::CH_MINUS:  plain(stl_pkg::K_MINUS, lx_line);
                stl_pkg::CH_COMMA:  plain(stl_pkg::K_COMMA, lx_line);
                stl_pkg::CH_SEMI:   plain(stl_pkg::K_SEMI, lx_line);
                stl_pkg::CH_LBRACE: plain(stl_pkg::K_LBRACE, lx_line);
                stl_pkg::CH_RBRACE: plain(stl_pkg::K_RBRACE, lx_line);
                stl_pkg::CH_LPAREN: plain(stl_pkg::K_LPAREN, lx_line);
                stl_pkg::CH_RPAREN: plain(stl_pkg::K_RPAREN, lx_line);
                stl_pkg::CH_SLASH:  lx_mode = stl_pkg::M_SLASH;
                stl_pkg::CH_LT:     lx_mode = stl_pkg::M_LT;
                stl_pkg::CH_GT:     lx_mode = stl_pkg::M_GT;
                stl_pkg::CH_BANG:   lx_mode = stl_pkg::M_BANG;
                stl_pkg::CH_EQ:     lx_mode = stl_pkg::M_EQ;
                stl_pkg::CH_AMP:    lx_mode = stl_pkg::M_AMP;
                stl_pkg::CH_BAR:    lx_mode = stl_pkg::M_BAR;
                stl_pkg::CH_ZERO: begin
                    lx_x_seen = 1'b0;
                    lx_hex    = '0;
                    lx_ovf    = 1'b0;
                    lx_mode   = stl_pkg::M_ZERO;
                end
                default: plain(stl_pkg::K_ERROR, lx_line);
            endcase
        end
    endfunction

    // Close the held token and rescan the byte that ended it
    function automatic void restart(input logic [7:0] c);
        close_held();
        open_tok(c);
    endfunction

    function automatic void pair(input logic [7:0] c, input logic [7:0] second,
                                 input logic [4:0] k);
        if (c == second) begin
            plain(k, lx_tok_line);
            lx_mode = stl_pkg::M_IDLE;
        end else begin
            restart(c);
        end
    endfunction

    // Advance the shadow lexer by one byte; returns the number of tokens caused
    function automatic int scan_byte(input logic [7:0] c, input logic fin);
        logic [4:0] d;
        step_n = 0;
        d = hex_digit(c);
        if (fin || c == stl_pkg::CH_NUL) begin
            close_held();
            plain(stl_pkg::K_EOS, lx_line);
            lx_line     = 16'd1;
            lx_tok_line = 16'd1;
        end else begin
            case (lx_mode)
                stl_pkg::M_IDLE: open_tok(c);
                stl_pkg::M_LINEC: begin
                    if (c == stl_pkg::CH_LF) begin
                        line_bump();
                        lx_mode = stl_pkg::M_IDLE;
                    end
                end
                stl_pkg::M_BLOCK: begin
                    if (c == stl_pkg::CH_STAR) lx_mode = stl_pkg::M_STAR;
                    else if (c == stl_pkg::CH_LF) line_bump();
                end
                stl_pkg::M_STAR: begin
                    if (c == stl_pkg::CH_SLASH) begin
                        lx_mode = stl_pkg::M_IDLE;
                    end else if (c != stl_pkg::CH_STAR) begin
                        if (c == stl_pkg::CH_LF) line_bump();
                        lx_mode = stl_pkg::M_BLOCK;
                    end
                end
                stl_pkg::M_SLASH: begin
                    if (c == stl_pkg::CH_SLASH) lx_mode = stl_pkg::M_LINEC;
                    else if (c == stl_pkg::CH_STAR) lx_mode = stl_pkg::M_BLOCK;
                    else restart(c);
                end
                stl_pkg::M_LT:   pair(c, stl_pkg::CH_EQ, stl_pkg::K_LE);
                stl_pkg::M_GT:   pair(c, stl_pkg::CH_EQ, stl_pkg::K_GE);
                stl_pkg::M_BANG: pair(c, stl_pkg::CH_EQ, stl_pkg::K_NE);
                stl_pkg::M_EQ:   pair(c, stl_pkg::CH_EQ, stl_pkg::K_EQEQ);
                stl_pkg::M_AMP:  pair(c, stl_pkg::CH_AMP, stl_pkg::K_AND);
                stl_pkg::M_BAR:  pair(c, stl_pkg::CH_BAR, stl_pkg::K_OR);
                stl_pkg::M_WORD: begin
                    if (is_lower(c)) begin
                        if (lx_wd_len < stl_pkg::WORD_MAX) lx_wd[lx_wd_len] = c;
                        if (lx_wd_len < stl_pkg::WORD_SAT) lx_wd_len = lx_wd_len + 3'd1;
                    end else begin
                        restart(c);
                    end
                end
                stl_pkg::M_IDSTART: begin
                    if (is_letter(c)) begin
                        id_add(c);
                        lx_mode = stl_pkg::M_IDENT;
                    end else begin
                        restart(c);
                    end
                end
                stl_pkg::M_IDENT: begin
                    if (is_letter(c) || is_digit(c)) id_add(c);
                    else restart(c);
                end
                stl_pkg::M_ZERO: begin
                    if (!lx_x_seen && c == stl_pkg::CH_LOW_X) begin
                        lx_x_seen = 1'b1;
                    end else if (lx_x_seen && d != NOT_HEX) begin
                        lx_hex  = 32'(d);
                        lx_mode = stl_pkg::M_HEX;
                    end else begin
                        restart(c);
                    end
                end
                default: begin
                    if (d != NOT_HEX) begin
                        if (lx_hex[31:28] != 4'd0) lx_ovf = 1'b1;
                        lx_hex = {lx_hex[27:0], d[3:0]};
                    end else begin
                        restart(c);
                    end
                end
            endcase
        end
        return step_n;
    endfunction

    function automatic void queue_byte(input logic [7:0] ch, input logic fin);
        t_src_beat b;
        b = '0;
        b.ch  = ch;
        b.fin = fin;
        src_q.push_back(b);
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
    endfunction

    function automatic logic [7:0] pick_char(input string set, input int n);
        return set[$urandom_range(0, n - 1)];
    endfunction

    function automatic logic [7:0] blank_byte();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = stl_pkg::CH_SPACE;
            1:       c = stl_pkg::CH_TAB;
            2:       c = stl_pkg::CH_CR;
            default: c = stl_pkg::CH_LF;
        endcase
        return c;
    endfunction

    function automatic void report(input string what, input t_exp_tok want,
                                   input t_exp_tok got);
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
            $display("%s at cycle %0d", what, cycles);
            $display("  expected kind %0d line %0d value %h ovf %b len %0d lo %h hi %h last %b",
                     want.kind, want.line_no, want.value, want.ovf, want.id_len, want.lo,
                     want.hi, want.last);
            $display("  actual   kind %0d line %0d value %h ovf %b len %0d lo %h hi %h last %b",
                     got.kind, got.line_no, got.value, got.ovf, got.id_len, got.lo,
                     got.hi, got.last);
        end
    endfunction

    // Check every accepted token beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            mon_got.kind    = o_kind;
            mon_got.line_no = o_line_no;
            mon_got.value   = o_number_value;
            mon_got.ovf     = o_number_overflow;
            mon_got.id_len  = o_ident_length;
            mon_got.lo      = o_ident_text_low;
            mon_got.hi      = o_ident_text_high;
            mon_got.last    = o_last;
            tok_seen++;
            if (pending_tokens.size() == 0) begin
                report("unexpected token", '0, mon_got);
            end else begin
                mon_want = pending_tokens.pop_front();
                if (mon_got !== mon_want) report("token mismatch", mon_want, mon_got);
            end
        end
    end

    // Receiver: one long hold-off early in the random phase, then changing stall patterns
    initial begin : sink
        int style;
        int k;
        int held;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rand_phase && !hold_done) begin
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_done = 1'b1;
            end
            style = $urandom_range(0, 3);
            for (k = 0; k < 32; k++) begin
                case (style)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    2:       i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= (k % 3 == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("cycle limit reached with %0d tokens outstanding", pending_tokens.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        t_src_beat beat;
        t_exp_tok  t;
        int        idx;
        int        i;
        int        n;
        int        burst;
        int        gap;
        int        pick;
        int        sel;
        int        drained;

        // Directed table first
        foreach (DIRECTED[j]) src_q.push_back(DIRECTED[j]);

        // Random token streams, mostly well formed, with noise and broken tokens
        rand_start = src_q.size();
        while (src_q.size() - rand_start < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 16) begin
                // keyword, now and then spoiled by a trailing letter
                queue_text(kw_words[$urandom_range(0, stl_pkg::KW_COUNT - 1)]);
                if ($urandom_range(0, 4) == 0) queue_byte(pick_char(alnum_chars, 26), 1'b0);
            end else if (pick < 22) begin
                n = $urandom_range(1, 8);
                repeat (n) queue_byte(pick_char(alnum_chars, 26), 1'b0);
            end else if (pick < 38) begin
                // identifier, a few past the length limit, a few without a letter
                queue_byte(stl_pkg::CH_UNDER, 1'b0);
                if ($urandom_range(0, 9) != 0) queue_byte(pick_char(alnum_chars, 52), 1'b0);
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 17) : $urandom_range(0, 6);
                repeat (n) queue_byte(pick_char(alnum_chars, 62), 1'b0);
            end else if (pick < 52) begin
                // hex literal: bare zero, 0x alone, short, or long enough to overflow
                queue_byte(stl_pkg::CH_ZERO, 1'b0);
                sel = $urandom_range(0, 9);
                if (sel != 0) begin
                    queue_byte(stl_pkg::CH_LOW_X, 1'b0);
                    n = (sel == 1) ? 0 : (sel < 4) ? $urandom_range(9, 12) : $urandom_range(1, 8);
                    repeat (n) queue_byte(pick_char(hex_chars, 22), 1'b0);
                end
            end else if (pick < 72) begin
                queue_text(op_words[$urandom_range(0, 21)]);
            end else if (pick < 78) begin
                // comment, sometimes cut off by end of stream
                n = $urandom_range(0, 10);
                if ($urandom_range(0, 1) == 0) begin
                    queue_text("//");
                    repeat (n) queue_byte(8'($urandom_range(1, 255)), 1'b0);
                    queue_byte(stl_pkg::CH_LF, 1'b0);
                end else begin
                    queue_text("/*");
                    repeat (n) begin
                        queue_byte(($urandom_range(0, 2) == 0) ? stl_pkg::CH_STAR
                                   : 8'($urandom_range(1, 255)), 1'b0);
                    end
                    if ($urandom_range(0, 7) != 0) queue_text("*/");
                    else queue_byte(8'($urandom_range(0, 255)), 1'b1);
                end
            end else if (pick < 86) begin
                queue_byte(blank_byte(), 1'b0);
            end else if (pick < 97) begin
                queue_byte(8'($urandom_range(1, 255)), 1'b0);
            end else if ($urandom_range(0, 1) == 0) begin
                queue_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                queue_byte(stl_pkg::CH_NUL, 1'b0);
            end
            if ($urandom_range(0, 1) == 0) queue_byte(blank_byte(), 1'b0);
        end
        queue_byte(stl_pkg::CH_SPACE, 1'b1);

        // Reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Send beats in bursts with random gaps
        burst = 0;
        for (idx = 0; idx < src_q.size(); idx++) begin
            beat = src_q[idx];
            if (idx == rand_start) rand_phase = 1'b1;
            if (burst == 0) begin
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                burst = $urandom_range(1, 40);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_valid   <= 1'b1;
            i_char_in <= beat.ch;
            i_is_end  <= beat.fin;
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            n = scan_byte(beat.ch, beat.fin);
            if (beat.known) begin
                t = '0;
                t.kind    = beat.kind;
                t.line_no = beat.line_no;
                t.last    = 1'b1;
                pending_tokens.push_back(t);
            end else begin
                for (i = 0; i < n; i++) begin
                    t = step_tok[i];
                    t.last = (i == n - 1);
                    pending_tokens.push_back(t);
                end
            end
            if (burst > 0) burst--;
        end
        i_valid <= 1'b0;

        // Drain, then watch a few more cycles for stray tokens
        drained = 0;
        while (pending_tokens.size() != 0 && drained < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drained++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_tokens.size() != 0) begin
            $display("%0d expected tokens never arrived", pending_tokens.size());
            fault_count += pending_tokens.size();
        end

        $display("Sent %0d byte beats: directed rows, then random token streams with noise.",
                 src_q.size());
        $display("Checked %0d tokens, output held off %0d cycles once, %0d faults.",
                 tok_seen, HOLD_CYCLES, fault_count);
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/stl_pkg.sv
rtl/stl_front.sv
rtl/stl_queue.sv
rtl/stl_back.sv
rtl/source_token_lexer.sv
verif/source_token_lexer_tb.sv
